// ===== rtl/rlce_pkg.sv =====
// Shared types and constants for the rainbow LED color engine.
// Used by rlce_ctrl, rlce_datapath and the top level; depends on nothing.
`default_nettype none

package rlce_pkg;

    // Field widths of the stream payloads.
    localparam int unsigned TIME_W  = 64;
    localparam int unsigned LED_W   = 6;
    localparam int unsigned COLOR_W = 24;
    localparam int unsigned LEVEL_W = 4;
    localparam int unsigned POS_W   = 11;
    localparam int unsigned SPEED_W = 7;

    // Color wheel geometry and speed limits.
    localparam logic [POS_W:0]    WHEEL_SIZE     = 12'd1536;
    localparam logic [POS_W:0]    LED_PITCH      = 12'd151;
    localparam logic [SPEED_W-1:0] SPEED_MAX     = 7'd100;
    localparam logic [SPEED_W-1:0] SPEED_MIN     = 7'd4;
    localparam logic [TIME_W-1:0] DECAY_INTERVAL = 64'd200000;

    // speed*95/100 equals (speed*62263)>>16 for every 7-bit speed.
    localparam logic [22:0] DECAY_RECIP = 23'd62263;

    // Request kinds carried on the input tuser bit.
    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_STIM = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             stim;     // raise the speed by one
        logic             advance;  // capture timestamp, step the wheel
        logic             issue;    // launch one LED into the color pipeline
        logic [LED_W-1:0] led;      // ordinal of the LED being launched
        logic             last;     // launched LED is the final one of the tick
        logic             decay;    // apply the timed speed decay
    } rlce_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pipe_adv;  // color pipeline moves this cycle
    } rlce_status_t;

endpackage

`default_nettype wire

// ===== rtl/rlce_ctrl.sv =====
// Controller state machine of the rainbow LED color engine.
// Sequences accept, per-LED issue and speed decay; depends on rlce_pkg.
`default_nettype none

module rlce_ctrl #(
    parameter int unsigned NUM_EFFECT_LEDS = 16
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    input  wire logic                  s_tuser,
    output logic                       s_tready,
    input  rlce_pkg::rlce_status_t     status,
    output rlce_pkg::rlce_cmd_t        cmd
);
    import rlce_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EMIT,
        ST_DECAY
    } state_t;

    localparam logic [LED_W-1:0] LAST_LED = LED_W'(NUM_EFFECT_LEDS - 1);

    state_t           state_reg;
    logic [LED_W-1:0] led_cnt_reg;
    logic             accept;

    // A new request is taken only between ticks.
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // Commands decoded from the current state.
    always_comb begin
        cmd.stim    = accept && (s_tuser == REQ_STIM);
        cmd.advance = accept && (s_tuser == REQ_TICK);
        cmd.issue   = (state_reg == ST_EMIT) && status.pipe_adv;
        cmd.led     = led_cnt_reg;
        cmd.last    = (led_cnt_reg == LAST_LED);
        cmd.decay   = (state_reg == ST_DECAY);
    end

    // State and LED counter.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            led_cnt_reg <= '0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (accept && (s_tuser == REQ_TICK)) begin
                        state_reg   <= ST_EMIT;
                        led_cnt_reg <= '0;
                    end
                end
                ST_EMIT: begin
                    if (status.pipe_adv) begin
                        if (led_cnt_reg == LAST_LED) begin
                            state_reg <= ST_DECAY;
                        end else begin
                            led_cnt_reg <= led_cnt_reg + 1'b1;
                        end
                    end
                end
                ST_DECAY: begin
                    state_reg <= ST_IDLE;
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/rlce_datapath.sv =====
// Datapath of the rainbow LED color engine: wheel state, speed control and
// a three-stage stallable color pipeline ending in the output register.
// Depends on rlce_pkg.
`default_nettype none

module rlce_datapath (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [rlce_pkg::LEVEL_W-1:0]  cfg_wr_data,
    input  wire logic [rlce_pkg::TIME_W-1:0]   time_us,
    input  rlce_pkg::rlce_cmd_t                cmd,
    output rlce_pkg::rlce_status_t             status,
    input  wire logic                          m_tready,
    output logic                               m_tvalid,
    output logic [rlce_pkg::LED_W-1:0]         m_led,
    output logic [rlce_pkg::COLOR_W-1:0]       m_color,
    output logic                               m_last
);
    import rlce_pkg::*;

    // Brightness multiplier for a level; levels above the table saturate.
    function automatic logic [7:0] bright_value(input logic [LEVEL_W-1:0] lvl);
        logic [7:0] val;
        if (lvl >= 4'd8) begin
            val = 8'd255;
        end else begin
            val = {lvl[2:0], 5'b00000};
        end
        return val;
    endfunction

    // Exact floor(p/255) for any product of two bytes.
    function automatic logic [7:0] div255(input logic [15:0] p);
        logic [16:0] s;
        s = {1'b0, p} + {9'd0, p[15:8]} + 17'd1;
        return s[15:8];
    endfunction

    // Square gamma: ((v+1)^2-1)>>8, low byte.
    function automatic logic [7:0] gamma(input logic [7:0] v);
        logic [16:0] vp;
        logic [16:0] sq;
        vp = {9'd0, v} + 17'd1;
        sq = vp * vp - 17'd1;
        return sq[15:8];
    endfunction

    logic [LEVEL_W-1:0] level_reg;
    logic [POS_W-1:0]   pos_reg;
    logic [SPEED_W-1:0] speed_reg;
    logic [TIME_W-1:0]  next_decay_reg;
    logic [TIME_W-1:0]  time_reg;
    logic [POS_W-1:0]   entry_reg;

    logic [POS_W:0]     pos_sum;
    logic [POS_W-1:0]   pos_next;
    logic [POS_W:0]     entry_sum;
    logic [POS_W-1:0]   entry_next;
    logic [22:0]        decay_prod;

    // Pipeline stage registers.
    logic               v1_reg, v2_reg, v3_reg;
    logic [LED_W-1:0]   led1_reg, led2_reg, led3_reg;
    logic               last1_reg, last2_reg, last3_reg;
    logic [7:0]         r1_reg, g1_reg, b1_reg;
    logic [15:0]        r2_reg, g2_reg, b2_reg;
    logic [COLOR_W-1:0] color3_reg;

    logic [7:0]         r_raw, g_raw, b_raw;
    logic [7:0]         ramp_up, ramp_dn, lvl_val;
    logic               adv;

    // The pipeline moves unless the output holds a transaction not yet taken.
    assign adv             = !v3_reg || m_tready;
    assign status.pipe_adv = adv;

    // Wheel step modulo the wheel size.
    assign pos_sum  = {1'b0, pos_reg} + {{(POS_W-SPEED_W+1){1'b0}}, speed_reg};
    assign pos_next = (pos_sum >= WHEEL_SIZE) ? POS_W'(pos_sum - WHEEL_SIZE)
                                              : pos_sum[POS_W-1:0];

    // Next LED's wheel entry, one pitch further on.
    assign entry_sum  = {1'b0, entry_reg} + LED_PITCH;
    assign entry_next = (entry_sum >= WHEEL_SIZE) ? POS_W'(entry_sum - WHEEL_SIZE)
                                                  : entry_sum[POS_W-1:0];

    assign decay_prod = {16'd0, speed_reg} * DECAY_RECIP;

    // Configuration, wheel, speed and decay timer state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg      <= 4'd8;
            pos_reg        <= '0;
            speed_reg      <= SPEED_MIN;
            next_decay_reg <= '0;
        end else begin
            if (cfg_wr_en) begin
                level_reg <= cfg_wr_data;
            end
            if (cmd.stim && (speed_reg < SPEED_MAX)) begin
                speed_reg <= speed_reg + 1'b1;
            end
            if (cmd.advance) begin
                pos_reg <= pos_next;
            end
            if (cmd.decay && (time_reg >= next_decay_reg)) begin
                next_decay_reg <= time_reg + DECAY_INTERVAL;
                if (speed_reg > SPEED_MIN) begin
                    speed_reg <= decay_prod[22:16];
                end
            end
        end
    end

    // Timestamp and entry walk; payload only.
    always_ff @(posedge aclk) begin
        if (cmd.advance) begin
            time_reg  <= time_us;
            entry_reg <= pos_next;
        end else if (cmd.issue) begin
            entry_reg <= entry_next;
        end
    end

    // Six-sector hue ramp for the current entry.
    assign ramp_up = entry_reg[7:0];
    assign ramp_dn = ~entry_reg[7:0];

    always_comb begin
        case (entry_reg[POS_W-1:8])
            3'd0: begin r_raw = ramp_up; g_raw = 8'd0;    b_raw = 8'd255;  end
            3'd1: begin r_raw = 8'd255;  g_raw = 8'd0;    b_raw = ramp_dn; end
            3'd2: begin r_raw = 8'd255;  g_raw = ramp_up; b_raw = 8'd0;    end
            3'd3: begin r_raw = ramp_dn; g_raw = 8'd255;  b_raw = 8'd0;    end
            3'd4: begin r_raw = 8'd0;    g_raw = 8'd255;  b_raw = ramp_up; end
            default: begin r_raw = 8'd0; g_raw = ramp_dn; b_raw = 8'd255;  end
        endcase
    end

    assign lvl_val = bright_value(level_reg);

    // Pipeline valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Stage 1 raw channels, stage 2 brightness products, stage 3 div255/gamma/pack.
    always_ff @(posedge aclk) begin
        if (adv) begin
            led1_reg   <= cmd.led;
            last1_reg  <= cmd.last;
            r1_reg     <= r_raw;
            g1_reg     <= g_raw;
            b1_reg     <= b_raw;

            led2_reg   <= led1_reg;
            last2_reg  <= last1_reg;
            r2_reg     <= {8'd0, r1_reg} * {8'd0, lvl_val};
            g2_reg     <= {8'd0, g1_reg} * {8'd0, lvl_val};
            b2_reg     <= {8'd0, b1_reg} * {8'd0, lvl_val};

            led3_reg   <= led2_reg;
            last3_reg  <= last2_reg;
            color3_reg <= {gamma(div255(g2_reg)), gamma(div255(r2_reg)),
                           gamma(div255(b2_reg))};
        end
    end

    assign m_tvalid = v3_reg;
    assign m_led    = led3_reg;
    assign m_color  = color3_reg;
    assign m_last   = last3_reg;

endmodule

`default_nettype wire

// ===== rtl/rainbow_led_color_engine.sv =====
// Top level of the rainbow LED color engine: stream ports, controller and
// datapath. Depends on rlce_pkg, rlce_ctrl and rlce_datapath.
//
// Usage:
//   Input stream: s_tuser selects the request (0 frame tick, 1 stimulate);
//   s_tdata carries the 64-bit microsecond timestamp of a tick.
//   A stimulate transaction raises the rotation speed (up to 100) and
//   produces nothing. A tick steps the wheel and produces one output
//   transaction per effect LED, in order, with m_tlast on the final one.
//   Output stream: m_tdata holds the LED ordinal and the GRB color.
//   cfg_wr_en/cfg_wr_data write the brightness level (0..8, above 8 is full).
// Timing:
//   A tick occupies the input from its accept through the launch of each LED
//   into the color pipeline and the speed decay step that follows.
//   A launched LED's color passes the stage 1, 2 and 3 registers; the pipeline
//   then delivers one color per cycle while m_tready is high.
//   When m_tready is low with a color waiting, the color pipeline and LED
//   launch halt, holding every color; no transaction is dropped.
// Reset: aresetn low sets brightness 8, wheel 0, speed 4, decay timer 0.
`default_nettype none

module rainbow_led_color_engine #(
    parameter int unsigned NUM_EFFECT_LEDS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Configuration: brightness level.
    input  wire logic        cfg_wr_en,
    input  wire logic [3:0]  cfg_wr_data,
    // Input stream.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // [63:0] time_us
    input  wire logic        s_tuser,   // [0] req_type
    // Output stream.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [5:0] led_ordinal, [29:6] color_grb, [31:30] zero
    output logic             m_tlast
);
    import rlce_pkg::*;

    rlce_cmd_t            cmd;
    rlce_status_t         status;
    logic [LED_W-1:0]     m_led;
    logic [COLOR_W-1:0]   m_color;

    // Sequencer for each request.
    rlce_ctrl #(
        .NUM_EFFECT_LEDS (NUM_EFFECT_LEDS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Wheel state and color pipeline.
    rlce_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .time_us     (s_tdata),
        .cmd         (cmd),
        .status      (status),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .m_led       (m_led),
        .m_color     (m_color),
        .m_last      (m_tlast)
    );

    // Pack the result fields, LED ordinal in the lowest bits.
    assign m_tdata = {2'b00, m_color, m_led};

endmodule

`default_nettype wire
